// File: src/efws_pkg.sv
// Package for the earliest-free-worker scheduler.
// Holds sizes, heap entry and request types, and the ordering and saturation functions.
// No dependencies.
`default_nettype none

package efws_pkg;

  localparam int NUM_WORKERS = 64;
  localparam int TIME_BITS   = 48;
  localparam int SLOT_W      = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int AW          = SLOT_W + 1;
  localparam int CNT_W       = $clog2(NUM_WORKERS + 1);
  localparam int CFG_W       = 7;
  localparam int CMP_W       = (CFG_W > CNT_W) ? CFG_W : CNT_W;
  localparam int DUR_W       = 32;
  localparam int WORKER_W    = 6;
  localparam int START_W     = 48;
  localparam int SUM_W       = ((TIME_BITS > DUR_W) ? TIME_BITS : DUR_W) + 1;
  localparam int CNT_RESET   = (NUM_WORKERS < 64) ? NUM_WORKERS : 64;

  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [TIME_BITS-1:0] ftime_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  localparam ftime_t TIME_MAX = '1;

  typedef struct packed {
    slot_t  worker;
    ftime_t free_time;
  } entry_t;

  typedef struct packed {
    logic  en;
    slot_t addr_a;
    slot_t addr_b;
  } rd_req_t;

  typedef struct packed {
    logic   en;
    slot_t  addr;
    entry_t data;
  } wr_req_t;

  typedef struct packed {
    logic  busy;
    slot_t pos;
  } status_t;

  function automatic logic entry_before(input entry_t a, input entry_t b);
    if (a.free_time != b.free_time) begin
      return a.free_time < b.free_time;
    end
    return a.worker < b.worker;
  endfunction

  function automatic ftime_t sat_finish(input ftime_t start, input logic [DUR_W-1:0] dur);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(start) + SUM_W'(dur);
    if (sum > SUM_W'(TIME_MAX)) begin
      return TIME_MAX;
    end
    return sum[TIME_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// File: src/efws_in_if.sv
// Job channel: valid/ready handshake carrying one job duration per item.
// Depends on efws_pkg.
`default_nettype none

interface efws_in_if;
  import efws_pkg::*;

  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] job_duration;

  modport source (output valid, output job_duration, input ready);
  modport sink   (input valid, input job_duration, output ready);
endinterface

`default_nettype wire

// File: src/efws_out_if.sv
// Assignment channel: valid/ready handshake carrying worker index and start time.
// Depends on efws_pkg.
`default_nettype none

interface efws_out_if;
  import efws_pkg::*;

  logic                valid;
  logic                ready;
  logic [WORKER_W-1:0] assigned_worker;
  logic [START_W-1:0]  start_tick;

  modport source (output valid, output assigned_worker, output start_tick, input ready);
  modport sink   (input valid, input assigned_worker, input start_tick, output ready);
endinterface

`default_nettype wire

// File: src/efws_heap_ram.sv
// Heap storage: one entry memory with two registered read ports and one write port.
// Per-slot valid bits make unwritten slots read as (slot index, time zero). Uses efws_pkg.
`default_nettype none

module efws_heap_ram (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  efws_pkg::rd_req_t rd_req,
  input  efws_pkg::wr_req_t wr_req,
  output efws_pkg::entry_t  rd_data_a,
  output efws_pkg::entry_t  rd_data_b
);
  import efws_pkg::*;

  entry_t                 mem [NUM_WORKERS];
  logic [NUM_WORKERS-1:0] vld_r;
  entry_t                 mem_a_r;
  entry_t                 mem_b_r;
  logic                   vld_a_r;
  logic                   vld_b_r;
  slot_t                  addr_a_r;
  slot_t                  addr_b_r;

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.addr] <= wr_req.data;
    end
    if (rd_req.en) begin
      mem_a_r  <= mem[rd_req.addr_a];
      mem_b_r  <= mem[rd_req.addr_b];
      vld_a_r  <= vld_r[rd_req.addr_a];
      vld_b_r  <= vld_r[rd_req.addr_b];
      addr_a_r <= rd_req.addr_a;
      addr_b_r <= rd_req.addr_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      vld_r <= '0;
    end else if (wr_req.en) begin
      vld_r[wr_req.addr] <= 1'b1;
    end
  end

  always_comb begin
    rd_data_a = vld_a_r ? mem_a_r : entry_t'{worker: addr_a_r, free_time: '0};
    rd_data_b = vld_b_r ? mem_b_r : entry_t'{worker: addr_b_r, free_time: '0};
  end

endmodule

`default_nettype wire

// File: src/efws_sift_ctrl.sv
// Sift-down sequencer: updates the root with the job's finish time and walks it down the heap.
// Keeps a copy of the root entry. Uses efws_pkg; drives efws_heap_ram.
`default_nettype none

module efws_sift_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clear,
  input  logic                     start,
  input  logic [efws_pkg::DUR_W-1:0] duration,
  input  efws_pkg::cnt_t           cnt,
  input  efws_pkg::entry_t         rd_data_a,
  input  efws_pkg::entry_t         rd_data_b,
  output efws_pkg::rd_req_t        rd_req,
  output efws_pkg::wr_req_t        wr_req,
  output efws_pkg::entry_t         root,
  output efws_pkg::status_t        status
);
  import efws_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  slot_t         pos_r, pos_nxt;
  entry_t        cur_r;
  entry_t        root_r;
  logic [AW-1:0] left, right, cnt_ext;
  logic          has_left, has_right, pick_right, swap;
  entry_t        best;
  slot_t         best_pos;

  always_comb begin
    left       = {pos_r, 1'b1};
    right      = left + AW'(1);
    cnt_ext    = AW'(cnt);
    has_left   = left < cnt_ext;
    has_right  = right < cnt_ext;
    pick_right = has_right && entry_before(rd_data_b, rd_data_a);
    best       = pick_right ? rd_data_b : rd_data_a;
    best_pos   = pick_right ? right[SLOT_W-1:0] : left[SLOT_W-1:0];
    swap       = entry_before(best, cur_r);
  end

  always_comb begin
    rd_req.en     = (state_r == ST_RD) && has_left;
    rd_req.addr_a = left[SLOT_W-1:0];
    rd_req.addr_b = right[SLOT_W-1:0];
    wr_req.en     = 1'b0;
    wr_req.addr   = pos_r;
    wr_req.data   = cur_r;
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RD;
          pos_nxt   = '0;
        end
      end
      ST_RD: begin
        if (has_left) begin
          state_nxt = ST_CMP;
        end else begin
          wr_req.en = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_CMP: begin
        wr_req.en = 1'b1;
        if (swap) begin
          wr_req.data = best;
          pos_nxt     = best_pos;
          state_nxt   = ST_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      state_r <= ST_IDLE;
      root_r  <= '{worker: '0, free_time: '0};
    end else begin
      state_r <= state_nxt;
      if (wr_req.en && pos_r == '0) begin
        root_r <= wr_req.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (state_r == ST_IDLE && start) begin
      cur_r <= '{worker: root_r.worker, free_time: sat_finish(root_r.free_time, duration)};
    end
  end

  assign root        = root_r;
  assign status.busy = (state_r != ST_IDLE);
  assign status.pos  = pos_r;

endmodule

`default_nettype wire

// File: src/earliest_free_worker_scheduler.sv
// Top level of the earliest-free-worker scheduler: config register, result buffering.
// Instantiates efws_sift_ctrl and efws_heap_ram; uses efws_pkg and the channel interfaces.
//
//  channel  | dir | payload                          | handshake
//  in_ch    | in  | job_duration[31:0]               | valid/ready
//  out_ch   | out | assigned_worker[5:0], start_tick | valid/ready
//  cfg_*    | in  | cfg_wdata[6:0] (worker_count)    | cfg_we, no wait
//
// An item is accepted in the idle state; the sift-down then spends a read and a compare state
// on each heap level that it visits, and one more read state when it ends at a leaf, paced
// by the memory read-compare-write loop per level.
// rst_n and a worker_count write rebuild the heap at once through per-slot valid bits.
// A result is buffered in an output register and one holding register, so a
// stalled output blocks new items only once both are full.
`default_nettype none

module earliest_free_worker_scheduler (
  input  logic                       clk,
  input  logic                       rst_n,
  efws_in_if.sink                    in_ch,
  efws_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [efws_pkg::CFG_W-1:0] cfg_wdata
);
  import efws_pkg::*;

  cnt_t             cnt_r;
  logic [CMP_W-1:0] cfg_ext;
  cnt_t             cnt_nxt;
  logic             acc, out_take, out_free;
  entry_t           out_ent_r, pend_ent_r;
  logic             out_vld_r, pend_vld_r;
  entry_t           root;
  entry_t           rd_data_a, rd_data_b;
  rd_req_t          rd_req;
  wr_req_t          wr_req;
  status_t          status;

  always_comb begin
    cfg_ext = CMP_W'(cfg_wdata);
    if (cfg_ext == '0) begin
      cnt_nxt = CNT_W'(1);
    end else if (cfg_ext > CMP_W'(NUM_WORKERS)) begin
      cnt_nxt = CNT_W'(NUM_WORKERS);
    end else begin
      cnt_nxt = CNT_W'(cfg_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_W'(CNT_RESET);
    end else if (cfg_we) begin
      cnt_r <= cnt_nxt;
    end
  end

  assign in_ch.ready = !status.busy && !pend_vld_r;
  assign acc         = in_ch.valid && in_ch.ready;
  assign out_take    = out_vld_r && out_ch.ready;
  assign out_free    = !out_vld_r || out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_vld_r <= pend_vld_r || acc;
      end
      if (out_free) begin
        pend_vld_r <= 1'b0;
      end else if (acc) begin
        pend_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_ent_r <= pend_vld_r ? pend_ent_r : root;
    end
    if (acc && !out_free) begin
      pend_ent_r <= root;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.assigned_worker = WORKER_W'(out_ent_r.worker);
  assign out_ch.start_tick      = START_W'(out_ent_r.free_time);

  efws_sift_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (cfg_we),
    .start     (acc),
    .duration  (in_ch.job_duration),
    .cnt       (cnt_r),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .rd_req    (rd_req),
    .wr_req    (wr_req),
    .root      (root),
    .status    (status)
  );

  efws_heap_ram u_ram (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (cfg_we),
    .rd_req    (rd_req),
    .wr_req    (wr_req),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

`ifndef SYNTHESIS
  a_pend_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> out_vld_r)
    else $error("holding register full while output register empty");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 && CMP_W'(cnt_r) <= CMP_W'(NUM_WORKERS))
    else $error("worker count out of range");

  a_pos_live: assert property (@(posedge clk) disable iff (!rst_n)
    status.busy |-> CMP_W'(status.pos) < CMP_W'(cnt_r))
    else $error("sift position beyond live slots");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> status.busy && out_vld_r)
    else $error("accepted item did not start a sift or post a result");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_req.en |-> CMP_W'(wr_req.addr) < CMP_W'(cnt_r))
    else $error("heap write outside live slots");
`endif

endmodule

`default_nettype wire
